@@ rtl/bfra_pkg.sv @@
`timescale 1ns / 1ps
package bfra_pkg;

    localparam int ADDR_BITS = 20;
    localparam int SW = ADDR_BITS + 1;
    localparam int NW = ADDR_BITS + 2;
    localparam int OW = ADDR_BITS;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_NO_FIT    = 3'd2;
    localparam logic [2:0] ST_NULL      = 3'd3;
    localparam logic [2:0] ST_DOUBLE    = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] REG_POOL     = 2'd0;
    localparam logic [1:0] REG_HEADER   = 2'd1;
    localparam logic [1:0] REG_COALESCE = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DECIDE = 5'b01000,
        S_SHIFT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic [SW-1:0] start;
        logic [SW-1:0] size;
    } t_region;

    typedef struct packed {
        logic          valid;
        logic [SW-1:0] start;
        logic [SW-1:0] size;
    } t_block;

endpackage

@@ rtl/best_fit_region_allocator.sv @@
`timescale 1ns / 1ps
// A request scans the block table (MAX_BLOCKS reads) and the free table in parallel, then
// decides, and shifts free table entries when a region is removed from or inserted into
// the free table; one request at a time.
// The result is strobed on o_valid for one cycle; the receiver cannot stall it.
// After reset and after every pool size write, a clearing pass over the MAX_BLOCKS block
// table entries keeps busy high.
module best_fit_region_allocator
    import bfra_pkg::*;
#(
    parameter int MAX_REGIONS = 64,
    parameter int MAX_BLOCKS  = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic          i_command,
    input  logic [20:0]   i_req_size,
    input  logic [19:0]   i_block_offset,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [20:0]   i_cfg_data,
    output logic          o_valid,
    output logic [2:0]    o_status,
    output logic [19:0]   o_result_offset,
    output logic [20:0]   o_free_bytes
);

    localparam int RI = $clog2(MAX_REGIONS);
    localparam int RC = $clog2(MAX_REGIONS + 1);
    localparam int BI = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int BC = $clog2(MAX_BLOCKS + 1);
    localparam logic [32:0] LIMIT = 33'(1) << ADDR_BITS;

    t_state        r_state;
    logic [SW-1:0] r_pool;
    logic [7:0]    r_hdr;
    logic          r_coal;
    logic [BC-1:0] r_cptr;
    logic [RC-1:0] r_fcnt;
    logic [SW-1:0] r_avail;

    logic          r_cmd;
    logic [NW-1:0] r_need;
    logic [SW-1:0] r_s;
    logic          r_neg;
    logic [OW-1:0] r_user;

    logic [RC-1:0] r_fptr;
    logic          r_fpend;
    logic [RI-1:0] r_fpidx;
    logic [BC-1:0] r_uptr;
    logic          r_upend;
    logic [BI-1:0] r_upidx;

    logic          r_best_ok;
    logic [RI-1:0] r_best_idx;
    t_region       r_best;
    logic          r_prev_ok;
    logic [RI-1:0] r_prev_idx;
    t_region       r_prev;
    logic          r_next_ok;
    logic [RI-1:0] r_next_idx;
    t_region       r_next;
    logic          r_uhit;
    logic [BI-1:0] r_uidx;
    logic [SW-1:0] r_usz;

    logic          r_down;
    logic [RC-1:0] r_rptr;
    logic [RC-1:0] r_left;
    logic          r_pend;
    logic [RI-1:0] r_pidx;
    logic [RI-1:0] r_pos;

    logic          r_valid;
    logic [2:0]    r_status;
    logic [OW-1:0] r_off;
    logic [SW-1:0] r_obytes;

    logic          f_we;
    logic [RI-1:0] f_wa;
    t_region       f_wd;
    logic [RI-1:0] f_ra;
    t_region       f_rd;
    logic          u_we;
    logic [BI-1:0] u_wa;
    t_block        u_wd;
    logic [BI-1:0] u_ra;
    t_block        u_rd;

    logic [SW-1:0] pool_eff;
    logic          accept;
    logic          scan_done;
    logic          join_prev;
    logic          join_next;
    logic [RC-1:0] pos;

    logic [2:0]    d_status;
    logic          d_fwe;
    logic [RI-1:0] d_fwa;
    t_region       d_fwd;
    logic          d_uwe;
    t_block        d_uwd;
    logic          d_shift;
    logic          d_down;
    logic [RC-1:0] d_rptr;
    logic [RC-1:0] d_left;
    logic [SW-1:0] d_avail;
    logic [OW-1:0] d_off;
    logic [SW-1:0] sum_n;

    bfra_ram #(.W(2 * SW), .DEPTH(MAX_REGIONS), .AW(RI)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_wa),
        .i_wdata (f_wd),
        .i_raddr (f_ra),
        .o_rdata (f_rd)
    );

    bfra_ram #(.W(2 * SW + 1), .DEPTH(MAX_BLOCKS), .AW(BI)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_wa),
        .i_wdata (u_wd),
        .i_raddr (u_ra),
        .o_rdata (u_rd)
    );

    assign pool_eff  = (33'(r_pool) > LIMIT) ? LIMIT[SW-1:0] : r_pool;
    assign busy      = (r_state != S_IDLE);
    assign accept    = start && (r_state == S_IDLE);
    assign scan_done = (r_fptr >= r_fcnt) && (r_uptr >= BC'(MAX_BLOCKS)) && !r_fpend && !r_upend;
    assign f_ra      = (r_state == S_SHIFT) ? r_rptr[RI-1:0] : r_fptr[RI-1:0];
    assign u_ra      = r_uptr[BI-1:0];
    assign pos       = r_next_ok ? RC'(r_next_idx) : r_fcnt;
    assign join_prev = r_coal && r_prev_ok
                       && (NW'(r_prev.start) + NW'(r_prev.size) == NW'(r_s));
    assign join_next = r_coal && r_next_ok && (NW'(r_s) + NW'(r_usz) == NW'(r_next.start));
    assign sum_n     = r_prev.size + r_usz;

    always_comb begin
        d_status = ST_OK;
        d_fwe    = 1'b0;
        d_fwa    = '0;
        d_fwd    = '0;
        d_uwe    = 1'b0;
        d_uwd    = '0;
        d_shift  = 1'b0;
        d_down   = 1'b1;
        d_rptr   = '0;
        d_left   = '0;
        d_avail  = r_avail;
        d_off    = '0;
        if (r_cmd == CMD_ALLOC) begin
            if (r_need > NW'(r_avail)) begin
                d_status = ST_TOO_LARGE;
            end else if (r_need == '0 || !r_best_ok) begin
                d_status = ST_NO_FIT;
            end else if (!r_uhit) begin
                d_status = ST_FULL;
            end else begin
                d_uwe   = 1'b1;
                d_uwd   = {1'b1, r_best.start, r_need[SW-1:0]};
                d_off   = OW'(r_best.start + SW'(r_hdr));
                d_avail = r_avail - r_need[SW-1:0];
                if (NW'(r_best.size) == r_need) begin
                    d_shift = 1'b1;
                    d_rptr  = RC'(r_best_idx) + RC'(1);
                    d_left  = r_fcnt - RC'(r_best_idx) - RC'(1);
                end else begin
                    d_fwe = 1'b1;
                    d_fwa = r_best_idx;
                    d_fwd = {r_best.start + r_need[SW-1:0], r_best.size - r_need[SW-1:0]};
                end
            end
        end else begin
            if (r_user == '0) begin
                d_status = ST_NULL;
            end else if (r_neg || !r_uhit) begin
                d_status = ST_DOUBLE;
            end else if (!join_prev && !join_next && r_fcnt >= RC'(MAX_REGIONS)) begin
                d_status = ST_FULL;
            end else begin
                d_uwe   = 1'b1;
                d_avail = r_avail + r_usz;
                if (join_prev && join_next) begin
                    d_fwe   = 1'b1;
                    d_fwa   = r_prev_idx;
                    d_fwd   = {r_prev.start, sum_n + r_next.size};
                    d_shift = 1'b1;
                    d_rptr  = pos + RC'(1);
                    d_left  = r_fcnt - pos - RC'(1);
                end else if (join_prev) begin
                    d_fwe = 1'b1;
                    d_fwa = r_prev_idx;
                    d_fwd = {r_prev.start, sum_n};
                end else if (join_next) begin
                    d_fwe = 1'b1;
                    d_fwa = r_next_idx;
                    d_fwd = {r_s, r_next.size + r_usz};
                end else begin
                    d_shift = 1'b1;
                    d_down  = 1'b0;
                    d_rptr  = r_fcnt - RC'(1);
                    d_left  = r_fcnt - pos;
                end
            end
        end
    end

    always_comb begin
        f_we = 1'b0;
        f_wa = '0;
        f_wd = '0;
        u_we = 1'b0;
        u_wa = r_uidx;
        u_wd = d_uwd;
        unique case (r_state)
            S_CLEAR: begin
                u_we = 1'b1;
                u_wa = r_cptr[BI-1:0];
                u_wd = '0;
                if (r_cptr == '0) begin
                    f_we = 1'b1;
                    f_wd = {SW'(0), pool_eff};
                end
            end
            S_DECIDE: begin
                f_we = d_fwe;
                f_wa = d_fwa;
                f_wd = d_fwd;
                u_we = d_uwe;
            end
            S_SHIFT: begin
                if (r_pend) begin
                    f_we = 1'b1;
                    f_wa = r_down ? (r_pidx - RI'(1)) : (r_pidx + RI'(1));
                    f_wd = f_rd;
                end else if (r_left == '0 && !r_down) begin
                    f_we = 1'b1;
                    f_wa = r_pos;
                    f_wd = {r_s, r_usz};
                end
            end
            default: begin
                f_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cptr   <= '0;
            r_pool   <= 21'h100000;
            r_hdr    <= 8'd24;
            r_coal   <= 1'b1;
            r_fcnt   <= '0;
            r_avail  <= '0;
            r_valid  <= 1'b0;
            r_fpend  <= 1'b0;
            r_upend  <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    if (r_cptr == '0) begin
                        r_fcnt  <= (pool_eff != '0) ? RC'(1) : RC'(0);
                        r_avail <= pool_eff;
                    end
                    r_cptr <= r_cptr + BC'(1);
                    if (r_cptr == BC'(MAX_BLOCKS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_cmd     <= i_command;
                        r_need    <= NW'(i_req_size) + NW'(r_hdr);
                        r_s       <= SW'(i_block_offset) - SW'(r_hdr);
                        r_neg     <= (i_block_offset < OW'(r_hdr));
                        r_user    <= i_block_offset;
                        r_fptr    <= '0;
                        r_uptr    <= '0;
                        r_fpend   <= 1'b0;
                        r_upend   <= 1'b0;
                        r_best_ok <= 1'b0;
                        r_prev_ok <= 1'b0;
                        r_next_ok <= 1'b0;
                        r_uhit    <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_fpend <= (r_fptr < r_fcnt);
                    r_fpidx <= r_fptr[RI-1:0];
                    if (r_fptr < r_fcnt) begin
                        r_fptr <= r_fptr + RC'(1);
                    end
                    r_upend <= (r_uptr < BC'(MAX_BLOCKS));
                    r_upidx <= r_uptr[BI-1:0];
                    if (r_uptr < BC'(MAX_BLOCKS)) begin
                        r_uptr <= r_uptr + BC'(1);
                    end
                    if (r_fpend) begin
                        if (r_cmd == CMD_ALLOC) begin
                            if (NW'(f_rd.size) >= r_need
                                && (!r_best_ok || f_rd.size < r_best.size)) begin
                                r_best_ok  <= 1'b1;
                                r_best_idx <= r_fpidx;
                                r_best     <= f_rd;
                            end
                        end else if (f_rd.start <= r_s) begin
                            r_prev_ok  <= 1'b1;
                            r_prev_idx <= r_fpidx;
                            r_prev     <= f_rd;
                        end else if (!r_next_ok) begin
                            r_next_ok  <= 1'b1;
                            r_next_idx <= r_fpidx;
                            r_next     <= f_rd;
                        end
                    end
                    if (r_upend && !r_uhit) begin
                        if ((r_cmd == CMD_ALLOC && !u_rd.valid)
                            || (r_cmd == CMD_FREE && u_rd.valid && u_rd.start == r_s)) begin
                            r_uhit <= 1'b1;
                            r_uidx <= r_upidx;
                            r_usz  <= u_rd.size;
                        end
                    end
                    if (scan_done) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_status <= d_status;
                    r_off    <= d_off;
                    r_avail  <= d_avail;
                    r_down   <= d_down;
                    r_rptr   <= d_rptr;
                    r_left   <= d_left;
                    r_pend   <= 1'b0;
                    r_pos    <= pos[RI-1:0];
                    if (d_shift) begin
                        r_state <= S_SHIFT;
                    end else begin
                        r_valid  <= 1'b1;
                        r_obytes <= d_avail;
                        r_state  <= S_IDLE;
                    end
                end
                S_SHIFT: begin
                    r_pend <= (r_left != '0);
                    r_pidx <= r_rptr[RI-1:0];
                    if (r_left != '0) begin
                        r_left <= r_left - RC'(1);
                        r_rptr <= r_down ? (r_rptr + RC'(1)) : (r_rptr - RC'(1));
                    end else if (!r_pend) begin
                        r_fcnt   <= r_down ? (r_fcnt - RC'(1)) : (r_fcnt + RC'(1));
                        r_valid  <= 1'b1;
                        r_obytes <= r_avail;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                    r_cptr  <= '0;
                end
            endcase
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_POOL: begin
                        r_pool  <= i_cfg_data;
                        r_cptr  <= '0;
                        r_state <= S_CLEAR;
                    end
                    REG_HEADER: begin
                        r_hdr <= i_cfg_data[7:0];
                    end
                    REG_COALESCE: begin
                        r_coal <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_result_offset = (r_status == ST_OK) ? r_off : '0;
    assign o_free_bytes    = r_obytes;

endmodule

@@ rtl/bfra_ram.sv @@
`timescale 1ns / 1ps
module bfra_ram #(
    parameter int W     = 42,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ dv/tb_best_fit_region_allocator.sv @@
`timescale 1ns / 1ps
module tb_best_fit_region_allocator;
    import bfra_pkg::*;

    localparam int NREG = 64;
    localparam int NBLK = 64;
    localparam bit [22:0] POOL_LIMIT = 23'd1 << 20;

    localparam logic [1:0] PICK_LITERAL = 2'd0;
    localparam logic [1:0] PICK_LIVE    = 2'd1;
    localparam logic [1:0] PICK_FREED   = 2'd2;
    localparam logic [1:0] PICK_NEAR    = 2'd3;

    typedef struct {
        logic        cmd;
        logic [20:0] req;
        logic [19:0] off;
        logic [1:0]  pick;
    } t_request;

    typedef struct {
        logic [2:0]  status;
        logic [19:0] offset;
        logic [20:0] free_b;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_command = CMD_ALLOC;
    logic [20:0] i_req_size = '0;
    logic [19:0] i_block_offset = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = REG_POOL;
    logic [20:0] i_cfg_data = '0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [19:0] o_result_offset;
    logic [20:0] o_free_bytes;

    best_fit_region_allocator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_req_size(i_req_size), .i_block_offset(i_block_offset),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_status(o_status), .o_result_offset(o_result_offset),
        .o_free_bytes(o_free_bytes)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_request    pending_requests[$];
    t_reply      expected_replies[$];
    logic [19:0] live_offsets[$];
    logic [19:0] freed_offsets[$];
    int          errors = 0;
    bit          no_idle = 0;

    // Shadow allocator state.
    bit [20:0] pool_reg;
    bit [7:0]  hdr_reg;
    bit        coal_reg;
    bit [22:0] reg_start[NREG];
    bit [22:0] reg_size[NREG];
    int        reg_cnt;
    bit [22:0] blk_start[NBLK];
    bit [22:0] blk_need[NBLK];
    bit        blk_live[NBLK];
    bit [22:0] avail;

    function automatic void restart_pool();
        bit [22:0] p;
        p = (pool_reg > POOL_LIMIT) ? POOL_LIMIT : 23'(pool_reg);
        for (int k = 0; k < NREG; k++) begin
            reg_start[k] = 0;
            reg_size[k] = 0;
        end
        for (int k = 0; k < NBLK; k++) blk_live[k] = 0;
        reg_size[0] = p;
        reg_cnt = (p != 0) ? 1 : 0;
        avail = p;
        live_offsets.delete();
        freed_offsets.delete();
    endfunction

    function automatic void drop_region(int idx);
        for (int k = idx; k + 1 < reg_cnt; k++) begin
            reg_start[k] = reg_start[k + 1];
            reg_size[k] = reg_size[k + 1];
        end
        reg_cnt--;
    endfunction

    function automatic logic [2:0] allocate(bit [22:0] req, output bit [22:0] off);
        bit [22:0] need;
        int best, slot;
        need = req + 23'(hdr_reg);
        off = 0;
        best = reg_cnt;
        slot = NBLK;
        if (need > avail) return ST_TOO_LARGE;
        if (need == 0) return ST_NO_FIT;
        for (int k = 0; k < reg_cnt; k++)
            if (reg_size[k] >= need && (best == reg_cnt || reg_size[k] < reg_size[best]))
                best = k;
        if (best == reg_cnt) return ST_NO_FIT;
        for (int k = NBLK - 1; k >= 0; k--)
            if (!blk_live[k]) slot = k;
        if (slot == NBLK) return ST_FULL;
        blk_live[slot] = 1;
        blk_start[slot] = reg_start[best];
        blk_need[slot] = need;
        off = reg_start[best] + 23'(hdr_reg);
        if (reg_size[best] == need) begin
            drop_region(best);
        end else begin
            reg_start[best] += need;
            reg_size[best] -= need;
        end
        avail -= need;
        return ST_OK;
    endfunction

    function automatic logic [2:0] release_block(bit [22:0] user);
        bit [22:0] s, n;
        int blk, pos;
        bit jp, jn;
        blk = NBLK;
        jp = 0;
        jn = 0;
        if (user == 0) return ST_NULL;
        if (user < 23'(hdr_reg)) return ST_DOUBLE;
        s = user - 23'(hdr_reg);
        for (int k = NBLK - 1; k >= 0; k--)
            if (blk_live[k] && blk_start[k] == s) blk = k;
        if (blk == NBLK) return ST_DOUBLE;
        n = blk_need[blk];
        pos = 0;
        while (pos < reg_cnt && reg_start[pos] <= s) pos++;
        if (coal_reg) begin
            jp = pos > 0 && reg_start[pos - 1] + reg_size[pos - 1] == s;
            jn = pos < reg_cnt && s + n == reg_start[pos];
        end
        if (jp && jn) begin
            reg_size[pos - 1] += n + reg_size[pos];
            drop_region(pos);
        end else if (jp) begin
            reg_size[pos - 1] += n;
        end else if (jn) begin
            reg_start[pos] = s;
            reg_size[pos] += n;
        end else begin
            if (reg_cnt >= NREG) return ST_FULL;
            for (int k = reg_cnt; k > pos; k--) begin
                reg_start[k] = reg_start[k - 1];
                reg_size[k] = reg_size[k - 1];
            end
            reg_start[pos] = s;
            reg_size[pos] = n;
            reg_cnt++;
        end
        blk_live[blk] = 0;
        avail += n;
        return ST_OK;
    endfunction

    function automatic t_reply predict_reply(logic cmd, logic [20:0] req, logic [19:0] boff);
        t_reply r;
        bit [22:0] off;
        off = 0;
        if (cmd == CMD_FREE) begin
            r.status = release_block(23'(boff));
            if (r.status == ST_OK) begin
                foreach (live_offsets[k])
                    if (live_offsets[k] == boff) begin
                        live_offsets.delete(k);
                        break;
                    end
                freed_offsets.push_back(boff);
                if (freed_offsets.size() > 8) void'(freed_offsets.pop_front());
            end
        end else begin
            r.status = allocate(23'(req), off);
            if (r.status == ST_OK) live_offsets.push_back(off[19:0]);
        end
        r.offset = (r.status == ST_OK) ? off[19:0] : 20'd0;
        r.free_b = avail[20:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Driver: the next request is resolved against the live and freed block lists when it is loaded.
    always @(posedge i_clk) begin : driver
        t_request it;
        logic [19:0] off;
        if (i_rst_n) begin
            if (start && !busy)
                expected_replies.push_back(predict_reply(i_command, i_req_size, i_block_offset));
            if (!(start && busy)) begin
                if (pending_requests.size() > 0 && (no_idle || $urandom_range(99) >= 35)) begin
                    it = pending_requests.pop_front();
                    off = it.off;
                    if (it.pick == PICK_LIVE && live_offsets.size() > 0)
                        off = live_offsets[$urandom_range(live_offsets.size() - 1)];
                    else if (it.pick == PICK_FREED && freed_offsets.size() > 0)
                        off = freed_offsets[$urandom_range(freed_offsets.size() - 1)];
                    else if (it.pick == PICK_NEAR && live_offsets.size() > 0)
                        off = 20'(live_offsets[$urandom_range(live_offsets.size() - 1)]
                                  + $urandom_range(1, 2) - 20'd3 + 20'd1);
                    start <= 1'b1;
                    i_command <= it.cmd;
                    i_req_size <= it.req;
                    i_block_offset <= off;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_reply w;
        if (i_rst_n && o_valid) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("unexpected transfer", 32'(o_status), 32'd0);
            end else begin
                w = expected_replies.pop_front();
                if (o_status !== w.status)
                    report_mismatch("status", 32'(o_status), 32'(w.status));
                if (o_result_offset !== w.offset)
                    report_mismatch("result_offset", 32'(o_result_offset), 32'(w.offset));
                if (o_free_bytes !== w.free_b)
                    report_mismatch("free_bytes", 32'(o_free_bytes), 32'(w.free_b));
            end
        end
    end

    task automatic add_req(logic cmd, logic [20:0] req, logic [19:0] off, logic [1:0] pick);
        t_request it;
        it.cmd = cmd;
        it.req = req;
        it.off = off;
        it.pick = pick;
        pending_requests.push_back(it);
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_requests.size() > 0 || expected_replies.size() > 0 || start || busy);
    endtask

    task automatic configure(bit [20:0] pool, bit [7:0] hdr, bit coal);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_POOL;
        i_cfg_data <= pool;
        @(posedge i_clk);
        pool_reg = pool;
        restart_pool();
        i_cfg_idx <= REG_HEADER;
        i_cfg_data <= {13'd0, hdr};
        @(posedge i_clk);
        hdr_reg = hdr;
        i_cfg_idx <= REG_COALESCE;
        i_cfg_data <= {20'd0, coal};
        @(posedge i_clk);
        coal_reg = coal;
        i_cfg_we <= 1'b0;
        repeat (3) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 55) begin
                r = $urandom_range(99);
                if (r < 80)
                    add_req(CMD_ALLOC, 21'($urandom_range(0, 300)), 20'($urandom),
                            PICK_LITERAL);
                else if (r < 95)
                    add_req(CMD_ALLOC, 21'($urandom_range(0, 20000)), 20'($urandom),
                            PICK_LITERAL);
                else
                    add_req(CMD_ALLOC, 21'($urandom_range(0, 2097151)), 20'($urandom),
                            PICK_LITERAL);
            end else begin
                r = $urandom_range(99);
                if (r < 70) add_req(CMD_FREE, 21'($urandom), 0, PICK_LIVE);
                else if (r < 80) add_req(CMD_FREE, 21'($urandom), 0, PICK_FREED);
                else if (r < 90) add_req(CMD_FREE, 21'($urandom), 0, PICK_NEAR);
                else if (r < 93) add_req(CMD_FREE, 21'($urandom), 0, PICK_LITERAL);
                else add_req(CMD_FREE, 21'($urandom), 20'($urandom_range(0, 1048575)),
                             PICK_LITERAL);
            end
        end
    endtask

    initial begin
        pool_reg = 21'd1048576;
        hdr_reg = 8'd24;
        coal_reg = 1'b1;
        restart_pool();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // Defaults from reset: edges of the request fields and the free error paths.
        add_req(CMD_ALLOC, 21'd0, 20'hFFFFF, PICK_LITERAL);
        add_req(CMD_ALLOC, 21'd1048576, 0, PICK_LITERAL);
        add_req(CMD_ALLOC, 21'h1FFFFF, 0, PICK_LITERAL);
        add_req(CMD_ALLOC, 21'd100, 0, PICK_LITERAL);
        add_req(CMD_ALLOC, 21'd100, 0, PICK_LITERAL);
        add_req(CMD_FREE, 21'h1FFFFF, 20'd0, PICK_LITERAL);
        add_req(CMD_FREE, 0, 20'd5, PICK_LITERAL);
        add_req(CMD_FREE, 0, 20'hFFFFF, PICK_LITERAL);
        add_req(CMD_FREE, 0, 0, PICK_LIVE);
        add_req(CMD_FREE, 0, 0, PICK_FREED);
        add_req(CMD_FREE, 0, 0, PICK_LIVE);
        add_req(CMD_ALLOC, 21'd1048528, 0, PICK_LITERAL);
        add_req(CMD_ALLOC, 21'd0, 0, PICK_LITERAL);
        add_req(CMD_FREE, 0, 20'd0, PICK_LITERAL);

        // Zero need, then the widest header.
        configure(21'd1048576, 8'd0, 1'b1);
        add_req(CMD_ALLOC, 21'd0, 0, PICK_LITERAL);
        add_req(CMD_ALLOC, 21'd1048576, 0, PICK_LITERAL);
        add_req(CMD_FREE, 0, 0, PICK_LIVE);
        configure(21'd1048576, 8'd255, 1'b1);
        add_req(CMD_ALLOC, 21'd1, 0, PICK_LITERAL);
        add_req(CMD_FREE, 0, 20'd254, PICK_LITERAL);
        add_req(CMD_FREE, 0, 0, PICK_LIVE);

        // Fill the block table, then fragment the region table without merging.
        configure(21'd4096, 8'd8, 1'b0);
        for (int k = 0; k < 65; k++) add_req(CMD_ALLOC, 21'd8, 0, PICK_LITERAL);
        for (int k = 0; k < 70; k++) add_req(CMD_FREE, 0, 0, PICK_LIVE);
        random_phase(60);

        configure(21'd1048576, 8'd24, 1'b1);
        no_idle = 1;
        random_phase(100);
        drain();
        no_idle = 0;
        configure(21'd4096, 8'd0, 1'b1);
        random_phase(80);
        configure(21'd1, 8'd255, 1'b0);
        random_phase(30);
        configure(21'h1FFFFF, 8'd16, 1'b0);
        random_phase(80);
        configure(21'd60000, 8'd3, 1'b1);
        random_phase(100);

        drain();
        repeat (300) @(posedge i_clk);
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
